// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block (mest_checker.sv).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mest_pkg.sv =====
// Shared constants and types of the MIDI event state tracker.
// No dependencies; used by mest_tbl, midi_event_state_tracker, mest_checker and tb.
`timescale 1ns / 1ps

package mest_pkg;

  // Default table depth (notes and controllers)
  localparam int unsigned TABLE_ENTRIES_DEF = 128;

  // Field widths
  localparam int unsigned DATA_W   = 7;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned BEND_W   = 14;
  localparam int unsigned ENERGY_W = 15;
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  // Code index values
  localparam logic [CODE_W-1:0] CODE_NOTE_OFF = 4'h8;
  localparam logic [CODE_W-1:0] CODE_NOTE_ON  = 4'h9;
  localparam logic [CODE_W-1:0] CODE_CONTROL  = 4'hB;
  localparam logic [CODE_W-1:0] CODE_BEND     = 4'hE;

  // Configuration register indexes
  localparam logic CFG_MOD_INDEX = 1'b0;
  localparam logic CFG_GAIN      = 1'b1;

  // Register reset values and limits
  localparam logic [DATA_W-1:0] MOD_INDEX_RST   = 7'd1;
  localparam logic [GAIN_W-1:0] GAIN_RST        = 9'd51;
  localparam logic [GAIN_W-1:0] GAIN_ONE        = 9'd256;
  localparam logic [DATA_W-1:0] LATEST_NOTE_RST = 7'd60;
  localparam logic [SUM_W-1:0]  SUM_CLAMP       = 14'd127;

  // Write request into a state table
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } tbl_wr_t;

endpackage

// ===== sv/mest_tbl.sv =====
// State table: synchronous memory with per-entry valid bits and write bypass.
// Depends on mest_pkg for widths and the write request struct.
`timescale 1ns / 1ps

module mest_tbl #(
  parameter int unsigned ENTRIES = mest_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [mest_pkg::DATA_W-1:0] rd_addr_i,
  output logic [mest_pkg::DATA_W-1:0] rd_data_o,
  input  mest_pkg::tbl_wr_t           wr_i
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [mest_pkg::DATA_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]          vld_q;
  logic [mest_pkg::DATA_W-1:0] mem_rd_q;
  logic                        vld_rd_q;
  logic                        byp_q;
  logic [mest_pkg::DATA_W-1:0] byp_data_q;
  logic [IW-1:0]               rd_idx;
  logic [IW-1:0]               wr_idx;

  assign rd_idx = rd_addr_i[IW-1:0];
  assign wr_idx = wr_i.addr[IW-1:0];

  // Write the array; a read registers the addressed entry and the write data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_idx];
      byp_data_q <= wr_i.data;
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= vld_q[rd_idx];
        byp_q    <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  // Forward a write that landed in the same cycle as the read
  assign rd_data_o = byp_q    ? byp_data_q :
                     vld_rd_q ? mem_rd_q   : '0;

endmodule

// ===== sv/midi_event_state_tracker.sv =====
// Top level of the MIDI event state tracker: stream ports, pipeline, energy update.
// Depends on mest_pkg and mest_tbl.
// Path: a tick is registered in the execute stage, then in the output register behind m_axis_tvalid.
// Throughput: one item per cycle; the table read at entry and the write-back in
// the next stage set this, and a tick waits only while a result is still held.
// Reset: tables read as zero at once through valid bits (no clearing pass).
`timescale 1ns / 1ps

module midi_event_state_tracker #(
  parameter int unsigned TABLE_ENTRIES = mest_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [mest_pkg::GAIN_W-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] code_index, [10:4] data_first, [17:11] data_second, [23:18] zero
  input  logic [mest_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                             s_axis_tuser,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [14:0] smoothed_energy, [28:15] pitch_bend, [35:29] mod_value,
  // [42:36] newest_note, [47:43] zero
  output logic [mest_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned DW = mest_pkg::DATA_W;

  // Configuration registers
  logic [DW-1:0]               mod_idx_q;
  logic [mest_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_idx_q <= mest_pkg::MOD_INDEX_RST;
      gain_q    <= mest_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mest_pkg::CFG_MOD_INDEX: mod_idx_q <= cfg_wdata_i[DW-1:0];
        mest_pkg::CFG_GAIN:      gain_q    <= cfg_wdata_i;
        default:                 gain_q    <= gain_q;
      endcase
    end
  end

  // Input transfer and table reads
  logic                        in_xfer;
  logic [DW-1:0]               in_first;
  logic [DW-1:0]               vel_old;
  logic [DW-1:0]               ctrl_rd;
  mest_pkg::tbl_wr_t           vel_wr;
  mest_pkg::tbl_wr_t           ctrl_wr;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_first = s_axis_tdata[10:4];

  mest_tbl #(.ENTRIES(TABLE_ENTRIES)) u_vel_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_first),
    .rd_data_o (vel_old),
    .wr_i      (vel_wr)
  );

  mest_tbl #(.ENTRIES(TABLE_ENTRIES)) u_ctrl_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (mod_idx_q),
    .rd_data_o (ctrl_rd),
    .wr_i      (ctrl_wr)
  );

  // Execute stage registers
  logic                        s1_vld_q;
  logic                        s1_op_q;
  logic [mest_pkg::CODE_W-1:0] s1_code_q;
  logic [DW-1:0]               s1_first_q;
  logic [DW-1:0]               s1_second_q;
  logic                        s1_fire;
  logic                        out_vld_q;

  assign s1_fire       = s1_vld_q && (!s1_op_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= s_axis_tuser;
      s1_code_q   <= s_axis_tdata[3:0];
      s1_first_q  <= in_first;
      s1_second_q <= s_axis_tdata[17:11];
    end
  end

  // Decode the packet in the execute stage
  logic s1_pkt;
  logic s1_in_range;
  logic is_on;
  logic is_off;
  logic is_ctrl;
  logic is_bend;
  logic mod_in_range;

  assign s1_pkt       = s1_fire && !s1_op_q;
  assign s1_in_range  = {1'b0, s1_first_q} < 8'(TABLE_ENTRIES);
  assign mod_in_range = {1'b0, mod_idx_q} < 8'(TABLE_ENTRIES);
  assign is_on   = s1_pkt && (s1_code_q == mest_pkg::CODE_NOTE_ON) && s1_in_range;
  assign is_off  = s1_pkt && (s1_code_q == mest_pkg::CODE_NOTE_OFF) && s1_in_range;
  assign is_ctrl = s1_pkt && (s1_code_q == mest_pkg::CODE_CONTROL) && s1_in_range;
  assign is_bend = s1_pkt && (s1_code_q == mest_pkg::CODE_BEND);

  // Write back the velocity and controller tables
  logic [DW-1:0] new_vel;

  assign new_vel = is_on ? s1_second_q : '0;

  always_comb begin
    vel_wr.en    = is_on || is_off;
    vel_wr.addr  = s1_first_q;
    vel_wr.data  = new_vel;
    ctrl_wr.en   = is_ctrl;
    ctrl_wr.addr = s1_first_q;
    ctrl_wr.data = s1_second_q;
  end

  // Running velocity sum, bend and latest note
  logic [mest_pkg::SUM_W-1:0]  sum_q;
  logic [mest_pkg::SUM_W-1:0]  sum_d;
  logic [mest_pkg::BEND_W-1:0] bend_q;
  logic [DW-1:0]               note_q;

  assign sum_d = sum_q - mest_pkg::SUM_W'(vel_old) + mest_pkg::SUM_W'(new_vel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bend_q <= '0;
      note_q <= mest_pkg::LATEST_NOTE_RST;
    end else begin
      if (vel_wr.en) begin
        sum_q <= sum_d;
      end
      if (is_bend) begin
        // Subtracting the center flips the top bit of the 14-bit value
        bend_q <= {~s1_second_q[DW-1], s1_second_q[DW-2:0], s1_first_q};
      end
      if (is_on && (s1_second_q != '0)) begin
        note_q <= s1_first_q;
      end
    end
  end

  // Energy smoothing on a tick
  logic [DW-1:0]                 clamp;
  logic signed [16:0]            diff;
  logic [mest_pkg::GAIN_W-1:0]   gain_sat;
  logic signed [26:0]            prod;
  logic signed [26:0]            energy_new;
  logic [mest_pkg::ENERGY_W-1:0] energy_q;
  logic                          tick_fire;

  assign tick_fire  = s1_fire && s1_op_q;
  assign clamp      = (sum_q > mest_pkg::SUM_CLAMP) ? mest_pkg::SUM_CLAMP[DW-1:0]
                                                    : sum_q[DW-1:0];
  assign diff       = $signed({2'b00, clamp, 8'h00}) - $signed({2'b00, energy_q});
  assign gain_sat   = (gain_q > mest_pkg::GAIN_ONE) ? mest_pkg::GAIN_ONE : gain_q;
  assign prod       = diff * $signed({1'b0, gain_sat});
  // Arithmetic shift floors toward minus infinity
  assign energy_new = $signed({12'd0, energy_q}) + (prod >>> 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else if (tick_fire) begin
      energy_q <= energy_new[mest_pkg::ENERGY_W-1:0];
    end
  end

  // Output register: load on a tick, hold until the transfer
  logic [mest_pkg::OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (tick_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_data_q <= {5'd0, note_q, (mod_in_range ? ctrl_rd : 7'd0), bend_q,
                     energy_new[mest_pkg::ENERGY_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/mest_checker.sv =====
// Port-level checker for the MIDI event state tracker, bound to the top level.
// Depends on mest_pkg, assert_macros.svh and midi_event_state_tracker.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mest_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mest_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic tick_xfer;
  logic m_stall;

  assign tick_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign m_stall   = m_axis_tvalid && !m_axis_tready;

  // A stalled result stays offered
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_stall, $stable(m_axis_tdata), "payload changed")

  // With no result held, the input side never blocks
  `ASSERT_IMP(a_in_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input blocked")

  // A new result only follows an accepted tick, through the execute stage and the output register
  `ASSERT_IMP(a_out_from_tick, clk_i, rst_ni, $rose(m_axis_tvalid), $past(tick_xfer, 2), "no tick")

endmodule

bind midi_event_state_tracker mest_checker u_mest_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the MIDI event state tracker top level.
// Depends on mest_pkg and midi_event_state_tracker; predicts every tick report.
`timescale 1ns / 1ps

module tb;
  import mest_pkg::*;

  localparam int unsigned TBL_DEPTH   = TABLE_ENTRIES_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 5000;
  localparam int          ENERGY_FULL = 32512;

  // One tick report as it sits on the master tdata bus, highest bits first
  typedef struct packed {
    logic [4:0]          pad;
    logic [DATA_W-1:0]   note;
    logic [DATA_W-1:0]   mod;
    logic [BEND_W-1:0]   bend;
    logic [ENERGY_W-1:0] energy;
  } tick_report_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic                   cfg_idx   = CFG_MOD_INDEX;
  logic [GAIN_W-1:0]      cfg_wdata = '0;
  logic                   src_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  src_data  = '0;
  logic                   src_user  = 1'b0;
  logic                   snk_ready = 1'b0;
  logic                   src_ready;
  logic                   snk_valid;
  logic [OUT_TDATA_W-1:0] snk_data;

  // Stimulus controls and bookkeeping
  bit src_idle_en  = 1'b0;
  bit snk_idle_en  = 1'b0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int snk_gap      = 0;
  int stall_cycles = 0;
  int error_count  = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int reports_seen = 0;
  int reg_writes   = 0;

  // Predicted block state
  logic [DATA_W-1:0] vel_tbl  [TBL_DEPTH];
  logic [DATA_W-1:0] ctrl_tbl [TBL_DEPTH];
  int                vel_sum;
  logic [BEND_W-1:0] bend_q;
  logic [DATA_W-1:0] latest_note_q;
  int                energy_q;
  logic [DATA_W-1:0] mod_idx_q;
  logic [GAIN_W-1:0] gain_q;

  tick_report_t expected_reports[$];

  midi_event_state_tracker #(
    .TABLE_ENTRIES(TBL_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(src_valid),
    .s_axis_tready(src_ready),
    .s_axis_tdata (src_data),
    .s_axis_tuser (src_user),
    .m_axis_tvalid(snk_valid),
    .m_axis_tready(snk_ready),
    .m_axis_tdata (snk_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic clear_tracker_state();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      vel_tbl[i]  = '0;
      ctrl_tbl[i] = '0;
    end
    vel_sum       = 0;
    bend_q        = '0;
    latest_note_q = LATEST_NOTE_RST;
    energy_q      = 0;
    mod_idx_q     = MOD_INDEX_RST;
    gain_q        = GAIN_RST;
  endtask

  // Replace one note velocity and keep the running sum in step
  task automatic store_velocity(logic [DATA_W-1:0] note, logic [DATA_W-1:0] vel);
    if (note < TBL_DEPTH) begin
      vel_sum -= vel_tbl[note];
      vel_tbl[note] = vel;
      vel_sum += vel;
    end
  endtask

  // Advance the predicted state by one accepted item; queue a report on a tick
  task automatic track_item(bit op, logic [CODE_W-1:0] code,
                            logic [DATA_W-1:0] first, logic [DATA_W-1:0] second);
    tick_report_t rep;
    int           clamped;
    int           gain_eff;
    int           diff;
    if (!op) begin
      case (code)
        CODE_NOTE_ON: begin
          if (first < TBL_DEPTH) begin
            store_velocity(first, second);
            if (second != 0) latest_note_q = first;
          end
        end
        CODE_NOTE_OFF: store_velocity(first, '0);
        CODE_CONTROL: begin
          if (first < TBL_DEPTH) ctrl_tbl[first] = second;
        end
        CODE_BEND: bend_q = {second, first} - 14'd8192;
        default: ;
      endcase
    end else begin
      clamped  = (vel_sum > SUM_CLAMP) ? int'(SUM_CLAMP) : vel_sum;
      gain_eff = (gain_q > GAIN_ONE) ? int'(GAIN_ONE) : int'(gain_q);
      diff     = (clamped <<< 8) - energy_q;
      // arithmetic shift rounds toward minus infinity
      energy_q += (diff * gain_eff) >>> 8;
      if (energy_q < 0) energy_q = 0;
      if (energy_q > ENERGY_FULL) energy_q = ENERGY_FULL;
      rep        = '0;
      rep.energy = energy_q[ENERGY_W-1:0];
      rep.bend   = bend_q;
      rep.mod    = (mod_idx_q < TBL_DEPTH) ? ctrl_tbl[mod_idx_q] : '0;
      rep.note   = latest_note_q;
      expected_reports.push_back(rep);
    end
  endtask

  // ---------------------------------------------------------------- driving

  // Offer one item, hold it until the transfer, then update the prediction
  task automatic send_item(bit op, logic [CODE_W-1:0] code,
                           logic [DATA_W-1:0] first, logic [DATA_W-1:0] second);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_user  <= op;
    src_data  <= {6'b0, second, first, code};
    do @(posedge clk_i); while (!src_ready);
    items_sent++;
    if (op) ticks_sent++;
    track_item(op, code, first, second);
  endtask

  task automatic send_packet(logic [CODE_W-1:0] code, logic [DATA_W-1:0] first,
                             logic [DATA_W-1:0] second);
    send_item(1'b0, code, first, second);
  endtask

  task automatic send_tick();
    send_item(1'b1, CODE_W'($urandom_range(0, 15)), DATA_W'($urandom_range(0, 127)),
              DATA_W'($urandom_range(0, 127)));
  endtask

  // Drop valid, drain all reports and let trailing packets settle
  task automatic wait_idle();
    src_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [GAIN_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == CFG_MOD_INDEX) mod_idx_q = value[DATA_W-1:0];
    else gain_q = value;
  endtask

  // Clear every held note so the velocity sum falls back below the clamp
  task automatic release_notes();
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (vel_tbl[i] != 0) send_packet(CODE_NOTE_OFF, DATA_W'(i), DATA_W'($urandom_range(0, 127)));
    end
  endtask

  // One random item; narrow keeps notes few and soft so the sum stays low
  task automatic send_random_item(bit narrow);
    int                r;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
    r      = $urandom_range(0, 99);
    first  = DATA_W'($urandom_range(0, 127));
    second = DATA_W'($urandom_range(0, 127));
    if (r < 55) begin
      code = (r < 38) ? CODE_NOTE_ON : CODE_NOTE_OFF;
      if (narrow) first = DATA_W'($urandom_range(0, 7));
      else if ($urandom_range(0, 9) < 7) first = DATA_W'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0: second = '0;
        1: second = DATA_W'($urandom_range(1, narrow ? 8 : 16));
        default: if (narrow) second = DATA_W'($urandom_range(1, 20));
      endcase
      send_packet(code, first, second);
    end else if (r < 67) begin
      if ($urandom_range(0, 1) == 0) first = mod_idx_q;
      send_packet(CODE_CONTROL, first, second);
    end else if (r < 75) begin
      send_packet(CODE_BEND, first, second);
    end else if (r < 93) begin
      send_tick();
    end else begin
      do code = CODE_W'($urandom_range(0, 15));
      while (code == CODE_NOTE_ON || code == CODE_NOTE_OFF ||
             code == CODE_CONTROL || code == CODE_BEND);
      send_packet(code, first, second);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Random ready bursts, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      snk_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      snk_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap   <= snk_gap - 1;
      snk_ready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
      snk_gap   <= $urandom_range(1, 11) - 1;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= 1'b1;
    end
  end

  // Compare each report transfer with the oldest prediction
  always @(posedge clk_i) begin
    tick_report_t got;
    tick_report_t want;
    if (rst_ni && snk_valid && snk_ready) begin
      got = tick_report_t'(snk_data);
      reports_seen++;
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: report with none predicted: energy %0d bend %0d mod %0d note %0d",
                   got.energy, $signed(got.bend), got.mod, got.note);
      end else begin
        want = expected_reports.pop_front();
        if (got.energy !== want.energy || got.bend !== want.bend ||
            got.mod !== want.mod || got.note !== want.note) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: report %0d: energy %0d/%0d bend %0d/%0d mod %0d/%0d note %0d/%0d",
                     reports_seen, want.energy, got.energy, $signed(want.bend),
                     $signed(got.bend), want.mod, got.mod, want.note, got.note);
        end
      end
    end
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (src_valid && src_ready) || (snk_valid && snk_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d reports outstanding",
               stall_cycles, expected_reports.size());
      $display("midi_event_state_tracker verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_tick();
    send_tick();
  endtask

  task automatic test_note_events();
    send_packet(CODE_NOTE_ON, 7'd0, 7'd127);
    send_packet(CODE_NOTE_ON, 7'd127, 7'd1);
    send_tick();
    // zero velocity clears and leaves the latest note alone
    send_packet(CODE_NOTE_ON, 7'd0, 7'd0);
    send_tick();
    send_packet(CODE_NOTE_OFF, 7'd127, 7'd85);
    send_tick();
    // sum above the clamp
    send_packet(CODE_NOTE_ON, 7'd64, 7'd127);
    send_packet(CODE_NOTE_ON, 7'd5, 7'd127);
    send_tick();
  endtask

  task automatic test_controls_and_bend();
    send_packet(CODE_CONTROL, 7'd1, 7'd127);
    send_packet(CODE_CONTROL, 7'd0, 7'd85);
    send_tick();
    send_packet(CODE_BEND, 7'd0, 7'd0);
    send_tick();
    send_packet(CODE_BEND, 7'd127, 7'd127);
    send_tick();
    send_packet(CODE_BEND, 7'd0, 7'd64);
    send_tick();
    // unknown codes change nothing
    send_packet(4'h0, 7'd127, 7'd127);
    send_packet(4'hF, 7'd127, 7'd127);
    send_packet(4'hA, 7'd42, 7'd0);
    send_tick();
  endtask

  task automatic test_register_extremes();
    write_register(CFG_MOD_INDEX, 9'd0);
    send_tick();
    write_register(CFG_MOD_INDEX, 9'd127);
    send_packet(CODE_CONTROL, 7'd127, 7'd42);
    send_tick();
    write_register(CFG_GAIN, 9'd0);
    send_tick();
    send_tick();
    write_register(CFG_GAIN, GAIN_ONE);
    send_tick();
    // gains above one land exactly on the target
    write_register(CFG_GAIN, 9'd511);
    send_packet(CODE_NOTE_OFF, 7'd64, 7'd0);
    send_packet(CODE_NOTE_OFF, 7'd5, 7'd0);
    send_packet(CODE_NOTE_ON, 7'd9, 7'd30);
    send_tick();
    write_register(CFG_GAIN, 9'd300);
    send_packet(CODE_NOTE_ON, 7'd10, 7'd90);
    send_tick();
    write_register(CFG_GAIN, 9'd1);
    send_packet(CODE_NOTE_OFF, 7'd10, 7'd0);
    send_tick();
    // upper write data bits are dropped for the controller index
    write_register(CFG_MOD_INDEX, 9'h181);
    send_tick();
    write_register(CFG_GAIN, GAIN_RST);
  endtask

  task automatic test_random_traffic();
    bit narrow;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_register(CFG_MOD_INDEX, GAIN_W'($urandom_range(0, 511)));
        1: write_register(CFG_MOD_INDEX, ($urandom_range(0, 1) == 0) ? 9'd0 : 9'd127);
        default: write_register(CFG_MOD_INDEX, GAIN_W'($urandom_range(0, 3)));
      endcase
      case (phase)
        1: write_register(CFG_GAIN, 9'd0);
        3: write_register(CFG_GAIN, GAIN_ONE);
        5: write_register(CFG_GAIN, 9'd511);
        default: write_register(CFG_GAIN, GAIN_W'($urandom_range(0, 511)));
      endcase
      narrow = (phase % 3 == 1);
      if (narrow || $urandom_range(0, 1) == 0) release_notes();
      repeat (190) send_random_item(narrow);
    end
  endtask

  // Hold the receiver off while the sender keeps offering ticks and random items
  task automatic test_backpressure();
    wait_idle();
    src_idle_en <= 1'b0;
    hold_asked  <= hold_asked + 1;
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) send_random_item(1'b0);
      else send_tick();
    end
    src_idle_en <= 1'b1;
  endtask

  task automatic test_last_stretch();
    wait_idle();
    write_register(CFG_GAIN, GAIN_W'($urandom_range(1, 255)));
    src_idle_en <= 1'b0;
    snk_idle_en <= 1'b0;
    repeat (150) send_random_item(1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_tracker_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_en <= 1'b1;
    snk_idle_en <= 1'b1;

    test_reset_state();
    test_note_events();
    test_controls_and_bend();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_last_stretch();

    src_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      error_count += expected_reports.size();
      $display("ERROR: %0d predicted reports never arrived", expected_reports.size());
    end

    $display("Run summary: %0d items in (%0d ticks), %0d reports checked, %0d register writes",
             items_sent, ticks_sent, reports_seen, reg_writes);
    $display("Exercised note, controller, bend and unknown packets, gain and index extremes,");
    $display("random stalls on both sides and a %0d-cycle receiver hold-off; %0d errors",
             HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("midi_event_state_tracker verification clean");
    end else begin
      $display("midi_event_state_tracker verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mest_pkg.sv
sv/mest_tbl.sv
sv/midi_event_state_tracker.sv
sv/mest_checker.sv
tb/sv/tb.sv
